// ===== rtl/kle_pkg.sv =====
// Shared types and constants of the keystroke line editor.
// No dependencies; used by keystroke_line_editor_core.
package kle_pkg;

  typedef enum logic [1:0] {
    ST_CONT  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ABORT = 2'd2,
    ST_BEEP  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FN_KEY     = 2'd0,
    FN_CLEAR   = 2'd1,
    FN_PRELOAD = 2'd2,
    FN_READ    = 2'd3
  } func_e;

  localparam logic [7:0] KEY_CTRL_A = 8'h01;
  localparam logic [7:0] KEY_CTRL_B = 8'h02;
  localparam logic [7:0] KEY_CTRL_C = 8'h03;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CTRL_E = 8'h05;
  localparam logic [7:0] KEY_CTRL_F = 8'h06;
  localparam logic [7:0] KEY_CTRL_G = 8'h07;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_CTRL_K = 8'h0B;
  localparam logic [7:0] KEY_CTRL_L = 8'h0C;
  localparam logic [7:0] KEY_CTRL_M = 8'h0D;
  localparam logic [7:0] KEY_CTRL_O = 8'h0F;
  localparam logic [7:0] KEY_CTRL_T = 8'h14;
  localparam logic [7:0] KEY_CTRL_Y = 8'h19;
  localparam logic [7:0] KEY_DEL    = 8'h7F;
  localparam logic [7:0] KEY_PRINT_LO = 8'h20;
  localparam logic [7:0] KEY_PRINT_HI = 8'h7E;

endpackage

// ===== rtl/keystroke_line_editor_core.sv =====
// Keystroke line editor: every accepted transfer gives exactly one result transfer. Cursor
// moves, mode toggles, clear, preload, done and abort go straight to the result state; a
// read passes through S_RD and a transpose through S_SWA, S_SWB and S_SWC first. Edits that
// move text (insert inside the line, delete, kill, overwrite yank) run a copy sequencer over
// the line and kill memories, one character per cycle through the single read port of each
// memory. A yank in insert mode shifts the tail and then copies the kill text in. The line
// holds at most LINE_DEPTH - 2 characters. One item is processed at a time; memory contents
// need no clearing after reset.
// Depends on kle_pkg and kle_ram.
module keystroke_line_editor_core
  import kle_pkg::*;
#(
  parameter int LINE_DEPTH = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // key[7:0], read_index[16:8], zero fill
  input  logic [1:0]  s_axis_tuser_i,  // func[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[1:0], cursor[10:2], length[19:11], read_char[27:20], overwrite_on[28], zero fill
  output logic [31:0] m_axis_tdata_o
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = (AW > 9) ? AW : 9;
  localparam logic [AW:0] MAX_LEN = (AW+1)'(LINE_DEPTH - 2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOVE = 3'd1;
  localparam logic [2:0] S_SWA  = 3'd2;
  localparam logic [2:0] S_SWB  = 3'd3;
  localparam logic [2:0] S_SWC  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] cur_q, cur_d, len_q, len_d, kl_q, kl_d;
  logic          ovw_q, ovw_d;
  logic [AW-1:0] mv_src_q, mv_src_d, mv_dst_q, mv_dst_d, mv_cnt_q, mv_cnt_d;
  logic          mv_dn_q, mv_dn_d, mv_ksrc_q, mv_ksrc_d, mv_kdst_q, mv_kdst_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic          tail_q, tail_d, yk_q, yk_d;
  logic [AW-1:0] tail_addr_q, tail_addr_d, yk_dst_q, yk_dst_d, sw_addr_q, sw_addr_d;
  logic [7:0]    tail_byte_q, tail_byte_d, sw_a_q, sw_a_d;
  status_e       res_st_q, res_st_d;
  logic [7:0]    res_rch_q, res_rch_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_data_q, out_data_d;

  logic          lw_en, kw_en;
  logic [AW-1:0] lw_addr, kw_addr, lr_addr, kr_addr;
  logic [7:0]    lw_data, kw_data, lr_data, kr_data;

  logic          acc;
  logic [7:0]    key;
  logic [CW-1:0] ridx_ext, cur_ext, len_ext;
  logic [AW:0]   len_w, cur_w, kl_w;
  logic [AW-1:0] pos;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign key      = s_axis_tdata_i[7:0];
  assign ridx_ext = CW'(s_axis_tdata_i[16:8]);
  assign cur_ext  = CW'(cur_q);
  assign len_ext  = CW'(len_q);
  assign len_w    = (AW+1)'(len_q);
  assign cur_w    = (AW+1)'(cur_q);
  assign kl_w     = (AW+1)'(kl_q);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  kle_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (lw_en),
    .waddr_i (lw_addr),
    .wdata_i (lw_data),
    .raddr_i (lr_addr),
    .rdata_o (lr_data)
  );

  kle_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_kill_ram (
    .clk_i   (clk_i),
    .we_i    (kw_en),
    .waddr_i (kw_addr),
    .wdata_i (kw_data),
    .raddr_i (kr_addr),
    .rdata_o (kr_data)
  );

  always_comb begin
    state_d = state_q;
    cur_d = cur_q;
    len_d = len_q;
    kl_d = kl_q;
    ovw_d = ovw_q;
    mv_src_d = mv_src_q;
    mv_dst_d = mv_dst_q;
    mv_cnt_d = mv_cnt_q;
    mv_dn_d = mv_dn_q;
    mv_ksrc_d = mv_ksrc_q;
    mv_kdst_d = mv_kdst_q;
    pend_d = 1'b0;
    pend_addr_d = pend_addr_q;
    tail_d = tail_q;
    tail_addr_d = tail_addr_q;
    tail_byte_d = tail_byte_q;
    yk_d = yk_q;
    yk_dst_d = yk_dst_q;
    sw_addr_d = sw_addr_q;
    sw_a_d = sw_a_q;
    res_st_d = res_st_q;
    res_rch_d = res_rch_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d = out_data_q;
    lw_en = 1'b0;
    lw_addr = '0;
    lw_data = '0;
    kw_en = 1'b0;
    kw_addr = '0;
    kw_data = '0;
    lr_addr = '0;
    kr_addr = '0;
    pos = cur_q;

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          res_st_d = ST_CONT;
          res_rch_d = '0;
          state_d = S_FIN;
          unique case (func_e'(s_axis_tuser_i))
            FN_CLEAR: begin
              len_d = '0;
              cur_d = '0;
            end
            FN_PRELOAD: begin
              if (len_w >= MAX_LEN) begin
                res_st_d = ST_BEEP;
              end else begin
                lw_en = 1'b1;
                lw_addr = len_q;
                lw_data = key;
                len_d = len_q + AW'(1);
                cur_d = len_q + AW'(1);
              end
            end
            FN_READ: begin
              if (ridx_ext < len_ext) begin
                lr_addr = ridx_ext[AW-1:0];
                state_d = S_RD;
              end
            end
            default: begin
              if (key >= KEY_PRINT_LO && key <= KEY_PRINT_HI) begin
                if (len_w >= MAX_LEN) begin
                  res_st_d = ST_BEEP;
                end else if (!ovw_q || cur_q == len_q) begin
                  len_d = len_q + AW'(1);
                  cur_d = cur_q + AW'(1);
                  if (cur_q == len_q) begin
                    lw_en = 1'b1;
                    lw_addr = cur_q;
                    lw_data = key;
                  end else begin
                    // Open a gap by shifting the tail up, then drop the key in.
                    mv_src_d = len_q - AW'(1);
                    mv_dst_d = len_q;
                    mv_cnt_d = len_q - cur_q;
                    mv_dn_d = 1'b1;
                    mv_ksrc_d = 1'b0;
                    mv_kdst_d = 1'b0;
                    tail_d = 1'b1;
                    tail_addr_d = cur_q;
                    tail_byte_d = key;
                    state_d = S_MOVE;
                  end
                end else begin
                  lw_en = 1'b1;
                  lw_addr = cur_q;
                  lw_data = key;
                  cur_d = cur_q + AW'(1);
                end
              end else begin
                unique case (key)
                  KEY_CTRL_A: cur_d = '0;
                  KEY_CTRL_B: begin
                    if (cur_q == '0) res_st_d = ST_BEEP;
                    else cur_d = cur_q - AW'(1);
                  end
                  KEY_CTRL_C, KEY_CTRL_G: res_st_d = ST_ABORT;
                  KEY_CTRL_E: cur_d = len_q;
                  KEY_CTRL_F: begin
                    if (cur_q >= len_q) res_st_d = ST_BEEP;
                    else cur_d = cur_q + AW'(1);
                  end
                  KEY_CTRL_D, KEY_CTRL_H, KEY_DEL: begin
                    pos = (key == KEY_CTRL_D) ? cur_q : cur_q - AW'(1);
                    if ((key == KEY_CTRL_D && cur_q >= len_q) ||
                        (key != KEY_CTRL_D && cur_q == '0)) begin
                      res_st_d = ST_BEEP;
                    end else begin
                      mv_src_d = pos + AW'(1);
                      mv_dst_d = pos;
                      mv_cnt_d = len_q - pos - AW'(1);
                      mv_dn_d = 1'b0;
                      mv_ksrc_d = 1'b0;
                      mv_kdst_d = 1'b0;
                      len_d = len_q - AW'(1);
                      cur_d = pos;
                      state_d = S_MOVE;
                    end
                  end
                  KEY_CTRL_K: begin
                    if (cur_q >= len_q) begin
                      res_st_d = ST_BEEP;
                    end else begin
                      kl_d = len_q - cur_q;
                      mv_src_d = cur_q;
                      mv_dst_d = '0;
                      mv_cnt_d = len_q - cur_q;
                      mv_dn_d = 1'b0;
                      mv_ksrc_d = 1'b0;
                      mv_kdst_d = 1'b1;
                      len_d = cur_q;
                      state_d = S_MOVE;
                    end
                  end
                  KEY_CTRL_L: res_st_d = ST_CONT;
                  KEY_CTRL_M: res_st_d = ST_DONE;
                  KEY_CTRL_O: ovw_d = !ovw_q;
                  KEY_CTRL_T: begin
                    if (cur_q == '0 || len_q <= cur_q) begin
                      res_st_d = ST_BEEP;
                    end else begin
                      lr_addr = cur_q - AW'(1);
                      sw_addr_d = cur_q;
                      state_d = S_SWA;
                    end
                  end
                  KEY_CTRL_Y: begin
                    if (kl_q == '0) begin
                      res_st_d = ST_BEEP;
                    end else if (!ovw_q) begin
                      if (len_w + kl_w >= MAX_LEN) begin
                        res_st_d = ST_BEEP;
                      end else begin
                        // Shift the tail up by the kill length, then copy the kill text in.
                        mv_src_d = len_q - AW'(1);
                        mv_dst_d = AW'(len_w + kl_w - (AW+1)'(1));
                        mv_cnt_d = len_q - cur_q;
                        mv_dn_d = 1'b1;
                        mv_ksrc_d = 1'b0;
                        mv_kdst_d = 1'b0;
                        yk_d = 1'b1;
                        yk_dst_d = cur_q;
                        len_d = AW'(len_w + kl_w);
                        cur_d = AW'(cur_w + kl_w);
                        state_d = S_MOVE;
                      end
                    end else begin
                      if (cur_w + kl_w >= MAX_LEN) begin
                        res_st_d = ST_BEEP;
                      end else begin
                        mv_src_d = '0;
                        mv_dst_d = cur_q;
                        mv_cnt_d = kl_q;
                        mv_dn_d = 1'b0;
                        mv_ksrc_d = 1'b1;
                        mv_kdst_d = 1'b0;
                        if (cur_w + kl_w > len_w) len_d = AW'(cur_w + kl_w);
                        cur_d = AW'(cur_w + kl_w);
                        state_d = S_MOVE;
                      end
                    end
                  end
                  default: res_st_d = ST_BEEP;
                endcase
              end
            end
          endcase
        end
      end
      S_MOVE: begin
        if (pend_q) begin
          if (mv_kdst_q) begin
            kw_en = 1'b1;
            kw_addr = pend_addr_q;
            kw_data = mv_ksrc_q ? kr_data : lr_data;
          end else begin
            lw_en = 1'b1;
            lw_addr = pend_addr_q;
            lw_data = mv_ksrc_q ? kr_data : lr_data;
          end
        end
        if (mv_cnt_q != '0) begin
          lr_addr = mv_src_q;
          kr_addr = mv_src_q;
          pend_d = 1'b1;
          pend_addr_d = mv_dst_q;
          mv_src_d = mv_dn_q ? mv_src_q - AW'(1) : mv_src_q + AW'(1);
          mv_dst_d = mv_dn_q ? mv_dst_q - AW'(1) : mv_dst_q + AW'(1);
          mv_cnt_d = mv_cnt_q - AW'(1);
        end else if (!pend_q) begin
          if (tail_q) begin
            lw_en = 1'b1;
            lw_addr = tail_addr_q;
            lw_data = tail_byte_q;
            tail_d = 1'b0;
            state_d = S_FIN;
          end else if (yk_q) begin
            mv_src_d = '0;
            mv_dst_d = yk_dst_q;
            mv_cnt_d = kl_q;
            mv_dn_d = 1'b0;
            mv_ksrc_d = 1'b1;
            mv_kdst_d = 1'b0;
            yk_d = 1'b0;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SWA: begin
        lr_addr = sw_addr_q;
        sw_a_d = lr_data;
        state_d = S_SWB;
      end
      S_SWB: begin
        lw_en = 1'b1;
        lw_addr = sw_addr_q - AW'(1);
        lw_data = lr_data;
        state_d = S_SWC;
      end
      S_SWC: begin
        lw_en = 1'b1;
        lw_addr = sw_addr_q;
        lw_data = sw_a_q;
        state_d = S_FIN;
      end
      S_RD: begin
        res_rch_d = lr_data;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d = {3'b000, ovw_q, res_rch_q, len_ext[8:0], cur_ext[8:0], res_st_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_q <= '0;
      len_q <= '0;
      kl_q <= '0;
      ovw_q <= 1'b0;
      mv_src_q <= '0;
      mv_dst_q <= '0;
      mv_cnt_q <= '0;
      mv_dn_q <= 1'b0;
      mv_ksrc_q <= 1'b0;
      mv_kdst_q <= 1'b0;
      pend_q <= 1'b0;
      pend_addr_q <= '0;
      tail_q <= 1'b0;
      tail_addr_q <= '0;
      tail_byte_q <= '0;
      yk_q <= 1'b0;
      yk_dst_q <= '0;
      sw_addr_q <= '0;
      sw_a_q <= '0;
      res_st_q <= ST_CONT;
      res_rch_q <= '0;
      out_valid_q <= 1'b0;
      out_data_q <= '0;
    end else begin
      state_q <= state_d;
      cur_q <= cur_d;
      len_q <= len_d;
      kl_q <= kl_d;
      ovw_q <= ovw_d;
      mv_src_q <= mv_src_d;
      mv_dst_q <= mv_dst_d;
      mv_cnt_q <= mv_cnt_d;
      mv_dn_q <= mv_dn_d;
      mv_ksrc_q <= mv_ksrc_d;
      mv_kdst_q <= mv_kdst_d;
      pend_q <= pend_d;
      pend_addr_q <= pend_addr_d;
      tail_q <= tail_d;
      tail_addr_q <= tail_addr_d;
      tail_byte_q <= tail_byte_d;
      yk_q <= yk_d;
      yk_dst_q <= yk_dst_d;
      sw_addr_q <= sw_addr_d;
      sw_a_q <= sw_a_d;
      res_st_q <= res_st_d;
      res_rch_q <= res_rch_d;
      out_valid_q <= out_valid_d;
      out_data_q <= out_data_d;
    end
  end

  a_cursor_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= len_q) else $error("cursor beyond line length");

  a_length_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_w <= MAX_LEN) else $error("line length over limit");

  a_no_stray_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_MOVE) |-> !pend_q) else $error("copy write pending outside move");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!tail_q && !yk_q)) else $error("follow-up left over in idle");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> !acc) else $error("two items accepted back to back");

endmodule

// ===== rtl/kle_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
